@@ rtl/f8c_pkg.sv @@
// Package with shared constants and types for the FP8/FP32 converter.
`timescale 1ns / 1ps
`default_nettype none
package f8c_pkg;

    typedef enum logic {
        CMD_DECODE = 1'b0,
        CMD_ENCODE = 1'b1
    } command_t;

    typedef enum logic {
        FMT_E4M3FN = 1'b0,
        FMT_E5M2   = 1'b1
    } fp8_format_t;

    localparam logic [31:0] F32_QNAN    = 32'h7fc0_0000;
    localparam logic [31:0] F32_INF     = 32'h7f80_0000;
    localparam logic [6:0]  E4_NAN_MAG  = 7'd127;
    localparam logic [6:0]  E5_INF_MAG  = 7'd124;

    typedef struct packed {
        command_t     command;
        logic [7:0]   fp8_byte;
        logic [31:0]  f32_bits;
    } in_item_t;

endpackage
`default_nettype wire

@@ rtl/f8c_if.sv @@
// Valid/ready channel interfaces for converter input and result items.
`timescale 1ns / 1ps
`default_nettype none
interface f8c_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  fp8_byte;
    logic [31:0] f32_bits;

    modport source (output valid, output command, output fp8_byte, output f32_bits,
                    input ready);
    modport sink (input valid, input command, input fp8_byte, input f32_bits,
                  output ready);
endinterface

interface f8c_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_f32;
    logic [7:0]  result_fp8;

    modport source (output valid, output result_f32, output result_fp8, input ready);
    modport sink (input valid, input result_f32, input result_fp8, output ready);
endinterface
`default_nettype wire

@@ rtl/fp8_f32_converter.sv @@
// Top level of the FP8/FP32 converter: input register, conversion and result register.
`timescale 1ns / 1ps
`default_nettype none
// Converts one value per item between an FP8 byte (E4M3FN or E5M2, chosen by
// the format register) and FP32 bits, with round to nearest even on encode.
// An item is taken into an input register, converted by a short combinational
// path and placed in a result register, which offers the result; one item is
// accepted in every cycle while results are taken.
// The format register should only be written while no items are in flight.
module fp8_f32_converter
    import f8c_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata,
    f8c_in_if.sink     in_ch,
    f8c_out_if.source  out_ch
);

    fp8_format_t fmt_reg;
    logic        s1_valid_reg;
    in_item_t    s1_item_reg;
    logic        s2_valid_reg;
    logic [31:0] s2_f32_reg;
    logic [7:0]  s2_fp8_reg;
    logic        s2_load;
    logic        s1_load;
    logic [31:0] dec_f32;
    logic [7:0]  enc_fp8;
    logic [31:0] res_f32_next;
    logic [7:0]  res_fp8_next;

    assign s2_load      = !s2_valid_reg || out_ch.ready;
    assign s1_load      = !s1_valid_reg || s2_load;
    assign in_ch.ready  = s1_load;

    f8c_decode u_decode (
        .fmt        (fmt_reg),
        .fp8_byte   (s1_item_reg.fp8_byte),
        .result_f32 (dec_f32)
    );

    f8c_encode u_encode (
        .fmt        (fmt_reg),
        .f32_bits   (s1_item_reg.f32_bits),
        .result_fp8 (enc_fp8)
    );

    assign res_f32_next = (s1_item_reg.command == CMD_DECODE) ? dec_f32 : 32'd0;
    assign res_fp8_next = (s1_item_reg.command == CMD_ENCODE) ? enc_fp8 : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg      <= FMT_E4M3FN;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                fmt_reg <= fp8_format_t'(cfg_wdata);
            if (s1_load)
                s1_valid_reg <= in_ch.valid;
            if (s2_load)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_ch.valid)
        begin
            s1_item_reg.command  <= command_t'(in_ch.command);
            s1_item_reg.fp8_byte <= in_ch.fp8_byte;
            s1_item_reg.f32_bits <= in_ch.f32_bits;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_f32_reg <= res_f32_next;
            s2_fp8_reg <= res_fp8_next;
        end
    end

    assign out_ch.valid      = s2_valid_reg;
    assign out_ch.result_f32 = s2_f32_reg;
    assign out_ch.result_fp8 = s2_fp8_reg;

endmodule
`default_nettype wire

@@ rtl/f8c_decode.sv @@
// Combinational FP8 to FP32 decoder for E4M3FN and E5M2.
`timescale 1ns / 1ps
`default_nettype none
module f8c_decode
    import f8c_pkg::*;
(
    input  var fp8_format_t fmt,
    input  wire logic [7:0]  fp8_byte,
    output logic [31:0]      result_f32
);

    logic [4:0]  expo;
    logic [2:0]  mant;
    logic [7:0]  exp_f32;
    logic [22:0] frac;
    logic [31:0] mag_bits;
    logic [6:0]  mag;

    always_comb
    begin
        mag = fp8_byte[6:0];
        if (fmt == FMT_E5M2)
        begin
            expo = fp8_byte[6:2];
            mant = {1'b0, fp8_byte[1:0]};
        end
        else
        begin
            expo = {1'b0, fp8_byte[6:3]};
            mant = fp8_byte[2:0];
        end

        exp_f32 = 8'd0;
        frac    = 23'd0;
        if (expo != 5'd0)
        begin
            exp_f32 = {3'b000, expo} + ((fmt == FMT_E5M2) ? 8'd112 : 8'd120);
            frac    = (fmt == FMT_E5M2) ? {mant[1:0], 21'd0} : {mant, 20'd0};
        end
        else if (mant != 3'd0)
        begin
            // Normalize on the top set bit of the mantissa.
            priority if (mant[2])
            begin
                exp_f32 = 8'd120;
                frac    = {mant[1:0], 21'd0};
            end
            else if (mant[1])
            begin
                exp_f32 = (fmt == FMT_E5M2) ? 8'd112 : 8'd119;
                frac    = {mant[0], 22'd0};
            end
            else
            begin
                exp_f32 = (fmt == FMT_E5M2) ? 8'd111 : 8'd118;
                frac    = 23'd0;
            end
        end

        mag_bits = {1'b0, exp_f32, frac};
        if (fmt == FMT_E4M3FN)
        begin
            if (mag == E4_NAN_MAG)
                mag_bits = F32_QNAN;
        end
        else
        begin
            if (mag == E5_INF_MAG)
                mag_bits = F32_INF;
            if (mag > E5_INF_MAG)
                mag_bits = F32_QNAN;
        end
        result_f32 = mag_bits | {fp8_byte[7], 31'd0};
    end

endmodule
`default_nettype wire

@@ rtl/f8c_encode.sv @@
// Combinational FP32 to FP8 encoder with round to nearest even and clamping.
`timescale 1ns / 1ps
`default_nettype none
module f8c_encode
    import f8c_pkg::*;
(
    input  var fp8_format_t fmt,
    input  wire logic [31:0] f32_bits,
    output logic [7:0]       result_fp8
);

    logic [30:0] abs_val;
    logic [7:0]  ef;
    logic [23:0] sig;
    logic [8:0]  s;
    logic [23:0] fl;
    logic [23:0] rem;
    logic [23:0] half;
    logic        up;
    logic        tie;
    logic [31:0] sum;
    logic [11:0] rounded;
    logic [11:0] code;
    logic [11:0] limit;
    logic        subnormal;

    always_comb
    begin
        abs_val   = f32_bits[30:0];
        subnormal = (fmt == FMT_E5M2) ? (abs_val < {8'd113, 23'd0})
                                      : (abs_val < {8'd121, 23'd0});
        ef  = abs_val[30:23];
        sig = {1'b1, abs_val[22:0]};
        if (ef == 8'd0)
        begin
            ef  = 8'd1;
            sig = {1'b0, abs_val[22:0]};
        end
        s = ((fmt == FMT_E5M2) ? 9'd134 : 9'd141) - {1'b0, ef};

        fl   = sig >> s[4:0];
        rem  = sig & ((24'd1 << s[4:0]) - 24'd1);
        half = 24'd1 << (s[4:0] - 5'd1);
        up   = (rem > half) || ((rem == half) && fl[0]);

        tie = (fmt == FMT_E5M2) ? abs_val[21] : abs_val[20];
        if (fmt == FMT_E5M2)
        begin
            sum     = {1'b0, abs_val} + 32'h000f_ffff + {31'd0, tie};
            rounded = {1'b0, sum[31:21]};
        end
        else
        begin
            sum     = {1'b0, abs_val} + 32'h0007_ffff + {31'd0, tie};
            rounded = sum[31:20];
        end

        if (subnormal)
        begin
            if (s > 9'd24)
                code = 12'd0;
            else
                code = fl[11:0] + {11'd0, up};
        end
        else
        begin
            code = rounded - ((fmt == FMT_E5M2) ? 12'd448 : 12'd960);
        end

        limit = (fmt == FMT_E5M2) ? {5'd0, E5_INF_MAG} : {5'd0, E4_NAN_MAG};
        if (code >= limit)
            code = limit;
        if (abs_val > 31'h7f80_0000)
            code = {5'd0, E4_NAN_MAG};
        result_fp8 = {f32_bits[31], code[6:0]};
    end

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the FP8/FP32 converter with random stalls on both channels.
`timescale 1ns / 1ps
module testbench;
    import f8c_pkg::*;

    typedef struct {
        logic [31:0] f32;
        logic [7:0]  fp8;
    } conv_result_t;

    typedef struct {
        command_t    cmd;
        logic [7:0]  byte_in;
        logic [31:0] bits_in;
        logic        has_exp;
        logic [31:0] exp_f32;
        logic [7:0]  exp_fp8;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    fp8_format_t fmt_model = FMT_E4M3FN;
    conv_result_t expected_q[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    stim_row_t rows[$];

    f8c_in_if in_ch();
    f8c_out_if out_ch();

    fp8_f32_converter DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] fp8_to_f32(logic [7:0] x, logic e5);
        int unsigned m, bias, expo, mant, p;
        logic [31:0] r;
        logic [6:0] mag;
        m = e5 ? 2 : 3;
        bias = e5 ? 15 : 7;
        expo = e5 ? x[6:2] : x[6:3];
        mant = x & ((1 << m) - 1);
        mag = x[6:0];
        if (expo != 0)
            r = ((expo + 127 - bias) << 23) | (mant << (23 - m));
        else if (mant == 0)
            r = 0;
        else
        begin
            p = 0;
            while (p < 2 && (mant >> (p + 1)) != 0)
                p++;
            r = ((128 + p - bias - m) << 23) | ((mant - (1 << p)) << (23 - p));
        end
        if (!e5 && mag == E4_NAN_MAG)
            r = F32_QNAN;
        if (e5 && mag == E5_INF_MAG)
            r = F32_INF;
        if (e5 && mag > E5_INF_MAG)
            r = F32_QNAN;
        return r | {x[7], 31'd0};
    endfunction

    function automatic logic [7:0] f32_to_fp8(logic [31:0] b, logic e5);
        longint unsigned m, bias, mag, sh, lim, code, ef, sig, s, fl, rem, half, tie;
        m = e5 ? 2 : 3;
        bias = e5 ? 15 : 7;
        mag = b[30:0];
        sh = 23 - m;
        lim = e5 ? 124 : 127;
        if (mag < ((128 - bias) << 23))
        begin
            ef = mag >> 23;
            sig = mag & 32'h7fffff;
            if (ef == 0)
                ef = 1;
            else
                sig |= 32'h800000;
            s = 151 - bias - m - ef;
            if (s > 24)
                code = 0;
            else
            begin
                fl = sig >> s;
                rem = sig & ((1 << s) - 1);
                half = 1 << (s - 1);
                code = fl + ((rem > half || (rem == half && fl[0])) ? 1 : 0);
            end
        end
        else
        begin
            tie = (mag >> sh) & 1;
            code = ((mag + ((1 << (sh - 1)) - 1) + tie) >> sh) - ((127 - bias) << m);
        end
        if (code >= lim)
            code = lim;
        if (mag > 32'h7f800000)
            code = 127;
        return {b[31], code[6:0]};
    endfunction

    function automatic conv_result_t convert(command_t cmd, logic [7:0] x, logic [31:0] b);
        conv_result_t r;
        r.f32 = 0;
        r.fp8 = 0;
        if (cmd == CMD_DECODE)
            r.f32 = fp8_to_f32(x, fmt_model);
        else
            r.fp8 = f32_to_fp8(b, fmt_model);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    task automatic send_item(command_t cmd, logic [7:0] x, logic [31:0] b,
                             logic has_exp, logic [31:0] ef, logic [7:0] e8);
        conv_result_t r;
        r = convert(cmd, x, b);
        if (has_exp && (r.f32 !== ef || r.fp8 !== e8))
            report_mismatch("table row", {r.f32[23:0], r.fp8}, {ef[23:0], e8});
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.fp8_byte <= x;
        in_ch.f32_bits <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_q.push_back(r);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_format(fp8_format_t f);
        cfg_we <= 1'b1;
        cfg_wdata <= f;
        @(posedge clk);
        cfg_we <= 1'b0;
        fmt_model = f;
    endtask

    function automatic logic [31:0] random_f32();
        logic [31:0] b;
        int k;
        b = $urandom;
        k = $urandom_range(9);
        if (k < 5)
            b[30:23] = 8'($urandom_range(100, 145));
        else if (k < 7)
            b[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        else if (k == 7)
            b[19:0] = $urandom_range(1) ? 20'h80000 : 20'h00000;
        return b;
    endfunction

    always @(posedge clk)
    begin
        conv_result_t e;
        if (out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected item", out_ch.result_f32, 0);
            else
            begin
                e = expected_q.pop_front();
                if (out_ch.result_f32 !== e.f32)
                    report_mismatch("result_f32", out_ch.result_f32, e.f32);
                if (out_ch.result_fp8 !== e.fp8)
                    report_mismatch("result_fp8", out_ch.result_fp8, e.fp8);
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #20000000;
        $display("[fp8_f32_converter] ERROR");
        $finish;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.command = CMD_DECODE;
        in_ch.fp8_byte = 8'd0;
        in_ch.f32_bits = 32'd0;
        out_ch.ready = 1'b0;
        rows = '{
            '{CMD_DECODE, 8'h00, 32'h0, 1, 32'h00000000, 8'h00},
            '{CMD_DECODE, 8'h7f, 32'h0, 1, 32'h7fc00000, 8'h00},
            '{CMD_DECODE, 8'hff, 32'h0, 1, 32'hffc00000, 8'h00},
            '{CMD_DECODE, 8'h80, 32'h0, 1, 32'h80000000, 8'h00},
            '{CMD_DECODE, 8'h01, 32'h0, 0, 32'h0, 8'h00},
            '{CMD_DECODE, 8'h7e, 32'h0, 0, 32'h0, 8'h00},
            '{CMD_DECODE, 8'h7c, 32'h0, 0, 32'h0, 8'h00},
            '{CMD_DECODE, 8'hfd, 32'h0, 0, 32'h0, 8'h00},
            '{CMD_DECODE, 8'h07, 32'h0, 0, 32'h0, 8'h00},
            '{CMD_ENCODE, 8'h00, 32'h00000000, 1, 32'h0, 8'h00},
            '{CMD_ENCODE, 8'h00, 32'h80000000, 1, 32'h0, 8'h80},
            '{CMD_ENCODE, 8'h00, 32'h7f800000, 0, 32'h0, 8'h00},
            '{CMD_ENCODE, 8'h00, 32'hff800000, 0, 32'h0, 8'h00},
            '{CMD_ENCODE, 8'h00, 32'h7fc00000, 1, 32'h0, 8'h7f},
            '{CMD_ENCODE, 8'h00, 32'hffffffff, 1, 32'h0, 8'hff},
            '{CMD_ENCODE, 8'h00, 32'h7f7fffff, 0, 32'h0, 8'h00},
            '{CMD_ENCODE, 8'h00, 32'h00000001, 1, 32'h0, 8'h00},
            '{CMD_ENCODE, 8'h00, 32'h3f800000, 0, 32'h0, 8'h00},
            '{CMD_ENCODE, 8'h00, 32'h3f880000, 0, 32'h0, 8'h00},
            '{CMD_ENCODE, 8'h00, 32'h3b000000, 0, 32'h0, 8'h00},
            '{CMD_ENCODE, 8'h00, 32'h3b800000, 0, 32'h0, 8'h00},
            '{CMD_ENCODE, 8'h00, 32'h37800000, 0, 32'h0, 8'h00},
            '{CMD_ENCODE, 8'h00, 32'h43e00000, 0, 32'h0, 8'h00}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].byte_in, rows[i].bits_in,
                      rows[i].has_exp, rows[i].exp_f32, rows[i].exp_fp8);
        drain();
        write_format(FMT_E5M2);
        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].byte_in, rows[i].bits_in, 1'b0, 0, 0);
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph % 3 == 0) ? 23 : (ph % 3 == 1) ? 84 : 0;
            recv_idle_pct = (ph % 3 == 0) ? 84 : (ph % 3 == 1) ? 23 : 0;
            write_format(ph[0] ? FMT_E5M2 : FMT_E4M3FN);
            for (int n = 0; n < 220; n++)
                send_item(command_t'($urandom_range(1)), 8'($urandom),
                          random_f32(), 1'b0, 0, 0);
            drain();
        end
        if (errors == 0)
            $display("[fp8_f32_converter] OK");
        else
            $display("[fp8_f32_converter] ERROR");
        $finish;
    end
endmodule
